>>> design/csd_pkg.sv
`default_nettype none

package csd_pkg;

  localparam int CoordW       = 16;
  localparam int CoefW        = 8;
  localparam int MaxMask      = 8;
  localparam int NormW        = CoefW + 2;
  localparam int AccW         = CoordW + CoefW + 2;
  localparam int NumW         = AccW;
  localparam int MaxControlDef = 64;
  localparam int MaxOutDef    = 1024;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_RUN    = 2'd2,
    OP_READ   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_OVF    = 3'd2,
    ST_NODATA = 3'd3,
    ST_BADIDX = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_MASK_LEN   = 2'd0,
    CFG_MASK_COEFS = 2'd1,
    CFG_STEPS      = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_PASS,
    S_CP0_RD,
    S_CP0_WR,
    S_TAP_RD,
    S_TAP_MAC,
    S_DIV,
    S_DIV_WAIT,
    S_CPL_RD,
    S_CPL_WR
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [9:0]         read_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [10:0]        point_count;
    logic [2:0]         status;
  } out_t;

  // round-to-nearest magnitude -> signed, saturated coordinate
  function automatic logic signed [CoordW-1:0] sat_quot(logic [NumW-1:0] q, logic neg);
    logic [NumW-1:0] lim;
    lim = NumW'(1) << (CoordW - 1);
    if (q >= lim) begin
      sat_quot = neg ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else if (neg) begin
      sat_quot = -$signed(q[CoordW-1:0]);
    end else begin
      sat_quot = $signed(q[CoordW-1:0]);
    end
  endfunction

endpackage

`default_nettype wire

>>> design/curve_stencil_subdivision_core.sv
`default_nettype none

// Curve stencil subdivision core.
// Commands enter on cmd_i, taken at a clock edge with start high and busy low.
// Each command gives exactly one result on res_o, shown for one cycle with
// done_o high; the receiver takes it at that edge and cannot stall it.
// Clear and append do not leave idle, and the next command may follow at once.
// A read goes through S_READ (one registered read of the result store).
// A run walks the stores with a multiply-accumulate per coordinate and the
// shared bit-serial divider: each pass checks for room, copies the first
// point, then per refined point accumulates each stencil tap and runs the
// rounding divide, and ends by copying the last point. busy is high meanwhile.
// Configuration writes go through cfg_valid_i/cfg_ready_o (always ready);
// the user must make them while the core is idle; it does not enforce this.
// Reset clears the point counts and the bank select and loads the default
// mask; the point stores are not cleared and never read before written.

module curve_stencil_subdivision_core import csd_pkg::*; #(
  parameter int MAX_CONTROL = MaxControlDef,
  parameter int MAX_OUT     = MaxOutDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         cmd_i,
  output logic             done_o,
  output out_t             res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int CIdxW = $clog2(MAX_CONTROL);
  localparam int CCntW = $clog2(MAX_CONTROL + 1);
  localparam int OIdxW = $clog2(MAX_OUT);
  localparam int OCntW = $clog2(MAX_OUT + 1);
  localparam int NW    = (OCntW > CCntW) ? OCntW : CCntW;
  localparam int TW    = NW + 2;
  localparam int PW    = 2 * CoordW;

  state_e state_q, state_d;

  logic [3:0]  mlen_q;
  logic [63:0] coefs_q;
  logic [2:0]  steps_q;

  logic [CCntW-1:0] ccount_q, ccount_d;
  logic [OCntW-1:0] rc_q, rc_d;
  logic             bank_q, bank_d;
  logic [2:0]       pass_q, pass_d;
  logic [NW-1:0]    n_q, n_d;
  logic [NW-1:0]    w_q, w_d;
  logic [NW-1:0]    idx_q, idx_d;
  logic [TW-1:0]    j_q, j_d;
  logic [TW-1:0]    jend_q, jend_d;
  logic [2:0]       t_q, t_d;
  logic signed [AccW-1:0] accx_q, accx_d, accy_q, accy_d;
  out_t             res_q, res_d;
  logic             done_q, done_d;

  // mask decode
  logic [3:0]              mlen;
  logic [3:0]              len1, len2, len;
  logic signed [NormW-1:0] norm;
  logic [2:0]              kidx;
  logic signed [CoefW-1:0] coef;

  always_comb begin
    if (mlen_q == 4'd0) begin
      mlen = 4'd1;
    end else if (mlen_q > 4'(MaxMask)) begin
      mlen = 4'(MaxMask);
    end else begin
      mlen = mlen_q;
    end
    len1 = mlen >> 1;
    len2 = mlen - len1;
    norm = '0;
    for (int k = 1; k < MaxMask; k += 2) begin
      if (4'(k) < mlen) begin
        norm = norm + NormW'($signed(coefs_q[k*CoefW +: CoefW]));
      end
    end
  end

  assign len  = j_q[0] ? len2 : len1;
  assign kidx = {t_q[1:0], ~j_q[0]};
  assign coef = $signed(coefs_q[{kidx, 3'b000} +: CoefW]);

  // stores
  logic [PW-1:0] ctrl_rd, a_rd, b_rd, src_rd, wdata;
  logic          ctrl_we, wr_en, we_a, we_b;
  logic [31:0]   wra, cra, wwa, cwa;
  logic signed [CoordW-1:0] qx, qy;
  logic          div_start, div_done;

  assign cra = 32'(idx_q);
  assign cwa = 32'(ccount_q);
  assign wra = (state_q == S_IDLE) ? 32'(cmd_i.read_index) : 32'(idx_q);
  assign wwa = 32'(w_q);
  assign we_a = wr_en && !pass_q[0];
  assign we_b = wr_en && pass_q[0];
  assign src_rd = (pass_q == 3'd0) ? ctrl_rd : (pass_q[0] ? a_rd : b_rd);

  csd_ram #(.Width(PW), .Depth(MAX_CONTROL)) u_ctrl_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_we),
    .waddr_i (cwa[CIdxW-1:0]),
    .wdata_i ({cmd_i.point_y, cmd_i.point_x}),
    .raddr_i (cra[CIdxW-1:0]),
    .rdata_o (ctrl_rd)
  );

  csd_ram #(.Width(PW), .Depth(MAX_OUT)) u_work_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (wwa[OIdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (wra[OIdxW-1:0]),
    .rdata_o (a_rd)
  );

  csd_ram #(.Width(PW), .Depth(MAX_OUT)) u_work_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (wwa[OIdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (wra[OIdxW-1:0]),
    .rdata_o (b_rd)
  );

  csd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_x_i (accx_q),
    .num_y_i (accy_q),
    .den_i   (norm),
    .done_o  (div_done),
    .q_x_o   (qx),
    .q_y_o   (qy)
  );

  // sequencer
  logic [NW:0]   np1, pairs;
  logic          extra;
  logic [TW-1:0] total;
  logic [TW-1:0] jn;
  logic [TW-1:0] jhalf;
  logic [NW-1:0] wn, idxn;
  logic          emit;
  status_e       st;
  logic signed [CoordW-1:0] ox, oy;
  logic [31:0]   rc32;
  logic signed [2*CoordW-1:0] px, py;

  assign np1   = {1'b0, n_q} + 1'b1;
  assign pairs = (np1 > (NW+1)'(len2)) ? np1 - (NW+1)'(len2) : '0;
  assign extra = len2 > len1;
  assign total = TW'(2) + TW'({pairs, 1'b0}) + TW'(extra);
  assign jn    = j_q + 1'b1;
  assign jhalf = jn >> 1;
  assign wn    = w_q + 1'b1;
  assign idxn  = (idx_q + 1'b1 == n_q) ? '0 : idx_q + 1'b1;
  assign px    = coef * $signed(src_rd[CoordW-1:0]);
  assign py    = coef * $signed(src_rd[PW-1:CoordW]);

  always_comb begin
    state_d   = state_q;
    ccount_d  = ccount_q;
    rc_d      = rc_q;
    bank_d    = bank_q;
    pass_d    = pass_q;
    n_d       = n_q;
    w_d       = w_q;
    idx_d     = idx_q;
    j_d       = j_q;
    jend_d    = jend_q;
    t_d       = t_q;
    accx_d    = accx_q;
    accy_d    = accy_q;
    ctrl_we   = 1'b0;
    wr_en     = 1'b0;
    wdata     = src_rd;
    div_start = 1'b0;
    emit      = 1'b0;
    st        = ST_OK;
    ox        = '0;
    oy        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (opcode_e'(cmd_i.opcode))
            OP_CLEAR: begin
              ccount_d = '0;
              emit     = 1'b1;
            end
            OP_APPEND: begin
              emit = 1'b1;
              if (32'(ccount_q) >= MAX_CONTROL) begin
                st = ST_FULL;
              end else begin
                ctrl_we  = 1'b1;
                ccount_d = ccount_q + 1'b1;
              end
            end
            OP_RUN: begin
              rc_d = '0;
              if (ccount_q == '0 || norm == '0) begin
                st   = ST_NODATA;
                emit = 1'b1;
              end else if (steps_q == 3'd0) begin
                emit = 1'b1;
              end else begin
                pass_d  = '0;
                n_d     = NW'(ccount_q);
                state_d = S_PASS;
              end
            end
            OP_READ: begin
              if (32'(cmd_i.read_index) >= 32'(rc_q)) begin
                st   = ST_BADIDX;
                emit = 1'b1;
              end else begin
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        emit    = 1'b1;
        ox      = bank_q ? $signed(b_rd[CoordW-1:0]) : $signed(a_rd[CoordW-1:0]);
        oy      = bank_q ? $signed(b_rd[PW-1:CoordW]) : $signed(a_rd[PW-1:CoordW]);
        state_d = S_IDLE;
      end
      S_PASS: begin
        if (32'(total) > MAX_OUT) begin
          rc_d    = '0;
          st      = ST_OVF;
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          jend_d  = total - TW'(2);
          w_d     = '0;
          idx_d   = '0;
          state_d = S_CP0_RD;
        end
      end
      S_CP0_RD: state_d = S_CP0_WR;
      S_CP0_WR: begin
        wr_en = 1'b1;
        w_d   = wn;
        j_d   = '0;
        if (jend_q == '0) begin
          idx_d   = n_q - 1'b1;
          state_d = S_CPL_RD;
        end else begin
          idx_d   = '0;
          t_d     = '0;
          accx_d  = '0;
          accy_d  = '0;
          state_d = S_TAP_RD;
        end
      end
      S_TAP_RD: state_d = S_TAP_MAC;
      S_TAP_MAC: begin
        accx_d = accx_q + AccW'(px);
        accy_d = accy_q + AccW'(py);
        idx_d  = idxn;
        t_d    = t_q + 1'b1;
        if ({1'b0, t_q} == len - 1'b1) begin
          state_d = S_DIV;
        end else begin
          state_d = S_TAP_RD;
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          wr_en = 1'b1;
          wdata = {qy, qx};
          w_d   = wn;
          j_d   = jn;
          if (jn == jend_q) begin
            idx_d   = n_q - 1'b1;
            state_d = S_CPL_RD;
          end else begin
            idx_d   = NW'(jhalf);
            t_d     = '0;
            accx_d  = '0;
            accy_d  = '0;
            state_d = S_TAP_RD;
          end
        end
      end
      S_CPL_RD: state_d = S_CPL_WR;
      S_CPL_WR: begin
        wr_en  = 1'b1;
        n_d    = wn;
        bank_d = pass_q[0];
        pass_d = pass_q + 1'b1;
        if (pass_q + 1'b1 == steps_q) begin
          rc_d    = OCntW'(wn);
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_PASS;
        end
      end
      default: state_d = S_IDLE;
    endcase

    rc32              = 32'(rc_d);
    done_d            = emit;
    res_d             = res_q;
    res_d.out_x       = ox;
    res_d.out_y       = oy;
    res_d.point_count = rc32[10:0];
    res_d.status      = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mlen_q   <= 4'd4;
      coefs_q  <= 64'd16974593;
      steps_q  <= 3'd1;
      ccount_q <= '0;
      rc_q     <= '0;
      bank_q   <= 1'b0;
      pass_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ccount_q <= ccount_d;
      rc_q     <= rc_d;
      bank_q   <= bank_d;
      pass_q   <= pass_d;
      done_q   <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MASK_LEN:   mlen_q  <= cfg_data_i[3:0];
          CFG_MASK_COEFS: coefs_q <= cfg_data_i;
          CFG_STEPS:      steps_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    w_q    <= w_d;
    idx_q  <= idx_d;
    j_q    <= j_d;
    jend_q <= jend_d;
    t_q    <= t_d;
    accx_q <= accx_d;
    accy_q <= accy_d;
    res_q  <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  a_ctrl_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_we |-> (32'(ccount_q) < MAX_CONTROL))
    else $error("control store written while full");

  a_one_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_a && we_b))
    else $error("both work banks written");

  a_work_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (32'(w_q) < MAX_OUT))
    else $error("work store write past end");

  a_quick_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.opcode == OP_CLEAR || cmd_i.opcode == OP_APPEND))
    |=> (done_o && !busy))
    else $error("clear or append did not finish in one cycle");

endmodule

`default_nettype wire

>>> design/csd_ram.sv
`default_nettype none

module csd_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/csd_div.sv
`default_nettype none

module csd_div import csd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [AccW-1:0]   num_x_i,
  input  wire logic signed [AccW-1:0]   num_y_i,
  input  wire logic signed [NormW-1:0]  den_i,
  output logic                          done_o,
  output logic signed [CoordW-1:0]      q_x_o,
  output logic signed [CoordW-1:0]      q_y_o
);

  localparam int CntW = $clog2(NumW);

  logic [NumW-1:0]  nx_q  [2];
  logic [NumW-1:0]  nx_d  [2];
  logic [NormW-1:0] rem_q [2];
  logic [NormW-1:0] rem_d [2];
  logic [1:0]       neg_q, neg_d;
  logic [NormW-1:0] md_q, md_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;

  logic signed [AccW-1:0] num [2];
  logic [NormW:0]         sh  [2];
  logic [NormW-1:0]       mdn;
  logic [AccW-1:0]        mag [2];

  assign num[0] = num_x_i;
  assign num[1] = num_y_i;

  always_comb begin
    mdn    = den_i[NormW-1] ? NormW'(-den_i) : NormW'(den_i);
    nx_d   = nx_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    md_d   = md_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    for (int l = 0; l < 2; l++) begin
      mag[l] = num[l][AccW-1] ? AccW'(-num[l]) : AccW'(num[l]);
      sh[l]  = {rem_q[l], nx_q[l][NumW-1]};
    end
    if (start_i) begin
      md_d  = mdn;
      cnt_d = '0;
      run_d = 1'b1;
      for (int l = 0; l < 2; l++) begin
        nx_d[l]  = mag[l] + AccW'(mdn >> 1);
        rem_d[l] = '0;
        neg_d[l] = num[l][AccW-1] ^ den_i[NormW-1];
      end
    end else if (run_q) begin
      for (int l = 0; l < 2; l++) begin
        if (sh[l] >= {1'b0, md_q}) begin
          rem_d[l] = NormW'(sh[l] - {1'b0, md_q});
          nx_d[l]  = {nx_q[l][NumW-2:0], 1'b1};
        end else begin
          rem_d[l] = sh[l][NormW-1:0];
          nx_d[l]  = {nx_q[l][NumW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q  <= nx_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    md_q  <= md_d;
  end

  assign done_o = done_q;
  assign q_x_o  = sat_quot(nx_q[0], neg_q[0]);
  assign q_y_o  = sat_quot(nx_q[1], neg_q[1]);

endmodule

`default_nettype wire
